// File: sv/psvs_pkg.sv
// Shared types and constants for the point-source visibility summer.
// Holds the request codes, control state type and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psvs_pkg;

    localparam int MAX_SOURCES_DEF = 256;

    localparam int FLUX_W = 24;
    localparam int POS_W  = 16;
    localparam int FREQ_W = 16;
    localparam int BASE_W = 24;
    localparam int SUM_W  = 48;
    localparam int USED_W = 9;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 16;
    localparam int CW_W         = 34;
    localparam int TRIG_W       = 17;   // Q1.15 plus room for the negated -1.0

    localparam logic [26:0]            TURN_SCALE = 27'd85445659;   // 2^29 / (2*pi)
    localparam logic signed [CW_W-1:0] CORDIC_X0  = 34'sd652032874;

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_LOAD    = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // atan(2^-i) in turns, one turn = 2^32
    function automatic logic signed [CW_W-1:0] rot_angle(input int idx);
        logic signed [CW_W-1:0] r;
        case (idx)
            0:       r = 34'sh020000000;
            1:       r = 34'sh012E4051E;
            2:       r = 34'sh009FB385B;
            3:       r = 34'sh0051111D4;
            4:       r = 34'sh0028B0D43;
            5:       r = 34'sh00145D7E1;
            6:       r = 34'sh000A2F61E;
            7:       r = 34'sh000517C55;
            8:       r = 34'sh00028BE53;
            9:       r = 34'sh000145F2F;
            10:      r = 34'sh0000A2F98;
            11:      r = 34'sh0000517CC;
            12:      r = 34'sh000028BE6;
            13:      r = 34'sh0000145F3;
            14:      r = 34'sh00000A2FA;
            15:      r = 34'sh00000517D;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/point_source_visibility_sum.sv
// Point-source visibility summer: source table in one synchronous memory,
// a pipelined phase / CORDIC / multiply-accumulate datapath behind it.
// Depends on psvs_pkg.
//
// Usage:
//   Input channel i_valid / o_stall carries requests: clear (empties the
//   table), load (appends one source, dropped when full) and compute.
//   Output channel o_valid / i_stall carries one result per compute request:
//   the 48-bit complex sum and the number of sources summed.
//   Clear and load give no result.
//   A compute request reads one source per cycle from the table memory and
//   streams it through a fixed pipeline (phase products, turn scaling,
//   16 CORDIC stages, flux multiply, accumulate).
//   For an empty table the result is given without running the pipeline.
//   One request is handled at a time: o_stall is high from an accepted
//   compute until its result is taken.
//   While the receiver stalls the result holds on the outputs.
//   Reset empties the table and the pipeline; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module point_source_visibility_sum #(
    parameter int MAX_SOURCES = psvs_pkg::MAX_SOURCES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [1:0]                         i_req_type,
    input  wire logic signed [psvs_pkg::FLUX_W-1:0] i_source_flux,
    input  wire logic signed [psvs_pkg::POS_W-1:0]  i_source_l,
    input  wire logic signed [psvs_pkg::POS_W-1:0]  i_source_m,
    input  wire logic [psvs_pkg::FREQ_W-1:0]        i_freq,
    input  wire logic signed [psvs_pkg::BASE_W-1:0] i_base_u,
    input  wire logic signed [psvs_pkg::BASE_W-1:0] i_base_v,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [psvs_pkg::SUM_W-1:0]       o_vis_re,
    output logic signed [psvs_pkg::SUM_W-1:0]       o_vis_im,
    output logic [psvs_pkg::USED_W-1:0]             o_sources_used
);
    import psvs_pkg::*;

    localparam int AW    = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int ENT_W = FLUX_W + 2 * POS_W;

    // ---------------- control ----------------
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count;     // sources stored
    logic [CNT_W-1:0] r_n;         // sources for current compute
    logic [AW-1:0]    r_j;
    logic [FREQ_W-1:0]        r_f;
    logic signed [BASE_W-1:0] r_u, r_v;

    logic acc_in;
    logic is_load, is_compute, is_clear;
    logic last_issue;
    logic pipe_busy;
    logic rd_en;

    assign acc_in     = i_valid && !o_stall;
    assign is_clear   = acc_in && (i_req_type == REQ_CLEAR);
    assign is_load    = acc_in && (i_req_type == REQ_LOAD);
    assign is_compute = acc_in && (i_req_type == REQ_COMPUTE);
    assign last_issue = ({{(CNT_W - AW + 1){1'b0}}, r_j} + (CNT_W + 1)'(1))
                        == {1'b0, r_n};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (is_compute) begin
                    n_state = (r_count == '0) ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        rd_en   = 1'b0;
        case (r_state)
            ST_IDLE:  o_stall = 1'b0;
            ST_RUN:   rd_en   = 1'b1;
            ST_DRAIN: ;
            ST_OUT:   o_valid = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_n     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (is_clear) begin
                r_count <= '0;
            end else if (is_load && (r_count < CNT_W'(MAX_SOURCES))) begin
                r_count <= r_count + 1'b1;
            end
            if (is_compute) begin
                r_n <= r_count;
                r_j <= '0;
            end else if (rd_en) begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_compute) begin
            r_f <= i_freq;
            r_u <= i_base_u;
            r_v <= i_base_v;
        end
    end

    // ---------------- source table ----------------
    logic [ENT_W-1:0] mem [MAX_SOURCES];
    logic [ENT_W-1:0] r_mem_q;
    logic             r_rd_v;

    always_ff @(posedge i_clk) begin
        if (is_load && (r_count < CNT_W'(MAX_SOURCES))) begin
            mem[r_count[AW-1:0]] <= {i_source_flux, i_source_l, i_source_m};
        end
        if (rd_en) begin
            r_mem_q <= mem[r_j];
        end
    end

    // ---------------- phase pipeline ----------------
    logic signed [FLUX_W-1:0] mq_flux;
    logic signed [POS_W-1:0]  mq_l, mq_m;
    assign mq_flux = r_mem_q[ENT_W-1 -: FLUX_W];
    assign mq_l    = r_mem_q[2*POS_W-1 -: POS_W];
    assign mq_m    = r_mem_q[POS_W-1:0];

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [FLUX_W-1:0] r_fl1, r_fl2, r_fl3, r_fl4, r_fl5;
    logic signed [39:0] r_pu, r_pv;
    logic signed [40:0] r_p;
    logic signed [57:0] r_a;
    logic [58:0] r_lo;
    logic [31:0] r_hi;
    logic [31:0] r_ang;

    logic signed [57:0] a_full;
    logic [63:0] a_ext;
    logic [63:0] x_full;
    logic [63:0] t_full;
    logic [58:0] hi_full;

    assign a_full  = $signed({1'b0, r_f}) * r_p;
    assign a_ext   = {{6{r_a[57]}}, r_a};
    assign hi_full = a_ext[63:32] * TURN_SCALE;
    assign x_full  = {r_hi, 32'b0} + {5'b0, r_lo};
    assign t_full  = 64'd0 - x_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
        end else begin
            r_rd_v <= rd_en;
            r_v1   <= r_rd_v;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pu  <= r_u * mq_l;
        r_pv  <= r_v * mq_m;
        r_fl1 <= mq_flux;
        r_p   <= 41'(r_pu) + 41'(r_pv);
        r_fl2 <= r_fl1;
        r_a   <= a_full;
        r_fl3 <= r_fl2;
        r_lo  <= a_ext[31:0] * TURN_SCALE;
        r_hi  <= hi_full[31:0];
        r_fl4 <= r_fl3;
        r_ang <= t_full[63:32];
        r_fl5 <= r_fl4;
    end

    // ---------------- CORDIC ----------------
    logic signed [CW_W-1:0]   r_cx [CORDIC_STEPS+1];
    logic signed [CW_W-1:0]   r_cy [CORDIC_STEPS+1];
    logic signed [CW_W-1:0]   r_cz [CORDIC_STEPS+1];
    logic                     r_cv [CORDIC_STEPS+1];
    logic                     r_cflip [CORDIC_STEPS+1];
    logic signed [FLUX_W-1:0] r_cf [CORDIC_STEPS+1];

    logic        fold;
    logic [31:0] z_fold;
    // fold into [-1/4, 1/4) turn by moving half a turn
    assign fold   = r_ang[31] ^ r_ang[30];
    assign z_fold = {r_ang[31] ^ fold, r_ang[30:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else begin
            r_cv[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0]    <= CORDIC_X0;
        r_cy[0]    <= '0;
        r_cz[0]    <= {{(CW_W - 32){z_fold[31]}}, z_fold};
        r_cflip[0] <= fold;
        r_cf[0]    <= r_fl5;
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[gi+1] <= 1'b0;
            end else begin
                r_cv[gi+1] <= r_cv[gi];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!r_cz[gi][CW_W-1]) begin
                r_cx[gi+1] <= r_cx[gi] - (r_cy[gi] >>> gi);
                r_cy[gi+1] <= r_cy[gi] + (r_cx[gi] >>> gi);
                r_cz[gi+1] <= r_cz[gi] - rot_angle(gi);
            end else begin
                r_cx[gi+1] <= r_cx[gi] + (r_cy[gi] >>> gi);
                r_cy[gi+1] <= r_cy[gi] - (r_cx[gi] >>> gi);
                r_cz[gi+1] <= r_cz[gi] + rot_angle(gi);
            end
            r_cflip[gi+1] <= r_cflip[gi];
            r_cf[gi+1]    <= r_cf[gi];
        end
    end

    // ---------------- round, multiply, accumulate ----------------
    function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CW_W-1:0] x,
                                                         input logic flip);
        logic signed [CW_W-1:0]   r;
        logic signed [TRIG_W-1:0] s;
        r = (x + CW_W'(1 << 14)) >>> 15;
        if (r > CW_W'(32767)) begin
            s = TRIG_W'(32767);
        end else if (r < -CW_W'(32768)) begin
            s = -TRIG_W'(32768);
        end else begin
            s = r[TRIG_W-1:0];
        end
        return flip ? -s : s;
    endfunction

    logic                     r_rv, r_mv;
    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic signed [FLUX_W-1:0] r_rf;
    logic signed [FLUX_W+TRIG_W-1:0] r_prc, r_prs;
    logic signed [FLUX_W+TRIG_W-1:0] rnd_c, rnd_s;
    logic signed [SUM_W-1:0] r_re, r_im;

    assign rnd_c = (r_prc + (FLUX_W + TRIG_W)'(1 << 14)) >>> 15;
    assign rnd_s = (r_prs + (FLUX_W + TRIG_W)'(1 << 14)) >>> 15;

    always_ff @(posedge i_clk) begin
        r_cos <= to_q15(r_cx[CORDIC_STEPS], r_cflip[CORDIC_STEPS]);
        r_sin <= to_q15(r_cy[CORDIC_STEPS], r_cflip[CORDIC_STEPS]);
        r_rf  <= r_cf[CORDIC_STEPS];
        r_prc <= r_rf * r_cos;
        r_prs <= r_rf * r_sin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
            r_mv <= 1'b0;
            r_re <= '0;
            r_im <= '0;
        end else begin
            r_rv <= r_cv[CORDIC_STEPS];
            r_mv <= r_rv;
            if (is_compute) begin
                r_re <= '0;
                r_im <= '0;
            end else if (r_mv) begin
                r_re <= r_re + {{(SUM_W - FLUX_W - TRIG_W){rnd_c[FLUX_W+TRIG_W-1]}}, rnd_c};
                r_im <= r_im + {{(SUM_W - FLUX_W - TRIG_W){rnd_s[FLUX_W+TRIG_W-1]}}, rnd_s};
            end
        end
    end

    always_comb begin
        pipe_busy = r_rd_v | r_v1 | r_v2 | r_v3 | r_v4 | r_v5 | r_rv | r_mv;
        for (int k = 0; k <= CORDIC_STEPS; k++) begin
            pipe_busy = pipe_busy | r_cv[k];
        end
    end

    logic [CNT_W+USED_W-1:0] used_ext;
    assign used_ext       = {{USED_W{1'b0}}, r_n};
    assign o_vis_re       = r_re;
    assign o_vis_im       = r_im;
    assign o_sources_used = used_ext[USED_W-1:0];

endmodule

`default_nettype wire
